// ===== rtl/gbre_pkg.sv =====
// ----------------------------------------------------------------------------
// gbre_pkg
// Shared types and constants of the glyph bitmap run extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package gbre_pkg;

	// Geometry limits, defaults for the top-level parameters
	localparam int MAX_GLYPH_WIDTH_DEF  = 255;
	localparam int MAX_GLYPH_HEIGHT_DEF = 255;

	// Runs one byte can complete: four inside the byte plus one at row end
	localparam int MAX_RUNS = 5;
	localparam int RUN_CW   = $clog2(MAX_RUNS + 1);
	localparam int RUN_IW   = $clog2(MAX_RUNS);

	// Entries between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [15:0] DRAW_COLOR_RESET = 16'hFFFF;

	// Stream widths
	localparam int S_TDATA_W = 96;
	localparam int M_TDATA_W = 56;

	typedef enum logic {
		KIND_HEADER = 1'b0,
		KIND_DATA   = 1'b1
	} item_kind_t;

	// Runs completed by one bitmap byte
	typedef struct packed {
		logic [15:0]                  x_base;
		logic [15:0]                  y;
		logic [RUN_CW-1:0]            count;
		logic [MAX_RUNS-1:0][7:0]     begins;
		logic [MAX_RUNS-1:0][7:0]     lens;
	} run_entry_t;

	// Queue status seen by the back end
	typedef struct packed {
		logic       valid;
		run_entry_t head;
	} queue_head_t;

endpackage

`default_nettype wire

// ===== rtl/gbre_front.sv =====
// ----------------------------------------------------------------------------
// gbre_front
// Accept header and bitmap items, track glyph position, scan each byte
// for completed runs and push them as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module gbre_front #(
	parameter int MAX_GLYPH_WIDTH  = gbre_pkg::MAX_GLYPH_WIDTH_DEF,
	parameter int MAX_GLYPH_HEIGHT = gbre_pkg::MAX_GLYPH_HEIGHT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           in_kind,
	input  wire logic [7:0]                     glyph_width,
	input  wire logic [7:0]                     glyph_height,
	input  wire logic [10:0]                    offset_x,
	input  wire logic [10:0]                    offset_y,
	input  wire logic [12:0]                    valid_byte_count,
	input  wire logic [15:0]                    pen_x,
	input  wire logic [15:0]                    base_y,
	input  wire logic [7:0]                     data_byte,
	input  wire logic                           q_full,
	output logic                                q_push,
	output gbre_pkg::run_entry_t                q_entry
);

	logic [7:0]  width_q;
	logic [7:0]  height_q;
	logic [15:0] left_x_q;
	logic [15:0] top_y_q;
	logic [12:0] valid_bytes_q;
	logic [12:0] byte_count_q;
	logic [7:0]  row_q;
	logic [4:0]  bir_q;
	logic        run_open_q;
	logic [7:0]  run_begin_q;

	logic        accept;
	logic        active;
	logic        row_end;
	logic [7:0]  bits;
	logic [7:0]  base;
	logic [7:0]  w_clamp;
	logic [7:0]  h_clamp;
	logic        open_n;
	logic [7:0]  begin_n;
	gbre_pkg::run_entry_t entry;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign active   = (width_q != 8'd0) && (row_q < height_q);
	assign bits     = (byte_count_q < valid_bytes_q) ? data_byte : 8'd0;
	assign base     = {bir_q, 3'b000};
	assign row_end  = ({1'b0, base} + 9'd8) >= {1'b0, width_q};

	assign w_clamp = ({2'b00, glyph_width} > 10'(MAX_GLYPH_WIDTH)) ?
		8'(MAX_GLYPH_WIDTH) : glyph_width;
	assign h_clamp = ({2'b00, glyph_height} > 10'(MAX_GLYPH_HEIGHT)) ?
		8'(MAX_GLYPH_HEIGHT) : glyph_height;

	// Scan the eight pixels of the byte, then close an open run at row end
	always_comb begin
		logic [7:0]                  col;
		logic                        pix;
		logic [gbre_pkg::RUN_CW-1:0] n;
		logic                        open_v;
		logic [7:0]                  begin_v;
		entry   = '0;
		n       = '0;
		open_v  = run_open_q;
		begin_v = run_begin_q;
		for (int b = 0; b < 8; b++) begin
			col = base + 8'(b);
			pix = bits[7 - b];
			if (col < width_q) begin
				if (pix && !open_v) begin
					open_v  = 1'b1;
					begin_v = col;
				end else if (!pix && open_v) begin
					entry.begins[n[gbre_pkg::RUN_IW-1:0]] = begin_v;
					entry.lens[n[gbre_pkg::RUN_IW-1:0]]   = col - begin_v;
					n      = n + 1'b1;
					open_v = 1'b0;
				end
			end
		end
		if (row_end && open_v) begin
			entry.begins[n[gbre_pkg::RUN_IW-1:0]] = begin_v;
			entry.lens[n[gbre_pkg::RUN_IW-1:0]]   = width_q - begin_v;
			n      = n + 1'b1;
			open_v = 1'b0;
		end
		entry.count  = n;
		entry.x_base = left_x_q;
		entry.y      = top_y_q + {8'd0, row_q};
		open_n       = open_v;
		begin_n      = begin_v;
	end

	assign q_entry = entry;
	assign q_push  = accept && (in_kind == gbre_pkg::KIND_DATA) && active &&
		(entry.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q       <= '0;
			height_q      <= '0;
			left_x_q      <= '0;
			top_y_q       <= '0;
			valid_bytes_q <= '0;
			byte_count_q  <= '0;
			row_q         <= '0;
			bir_q         <= '0;
			run_open_q    <= 1'b0;
			run_begin_q   <= '0;
		end else if (accept) begin
			if (in_kind == gbre_pkg::KIND_HEADER) begin
				width_q       <= w_clamp;
				height_q      <= h_clamp;
				left_x_q      <= pen_x + {{5{offset_x[10]}}, offset_x};
				top_y_q       <= base_y + {{5{offset_y[10]}}, offset_y};
				valid_bytes_q <= valid_byte_count;
				byte_count_q  <= '0;
				row_q         <= '0;
				bir_q         <= '0;
				run_open_q    <= 1'b0;
				run_begin_q   <= '0;
			end else if (active) begin
				byte_count_q <= byte_count_q + 13'd1;
				run_open_q   <= open_n;
				run_begin_q  <= begin_n;
				if (row_end) begin
					row_q <= row_q + 8'd1;
					bir_q <= '0;
				end else begin
					bir_q <= bir_q + 5'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gbre_queue.sv =====
// ----------------------------------------------------------------------------
// gbre_queue
// Short register queue of run entries between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gbre_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire gbre_pkg::run_entry_t  push_entry,
	output logic                       full,
	input  wire logic                  pop,
	output gbre_pkg::queue_head_t      head
);

	gbre_pkg::run_entry_t           mem_q [gbre_pkg::QDEPTH];
	logic [gbre_pkg::QAW-1:0]       wr_ptr_q;
	logic [gbre_pkg::QAW-1:0]       rd_ptr_q;
	logic [gbre_pkg::QCW-1:0]       count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full       = (count_q == gbre_pkg::QCW'(gbre_pkg::QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.head  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	function automatic logic [gbre_pkg::QAW-1:0] bump(input logic [gbre_pkg::QAW-1:0] p);
		return (p == gbre_pkg::QAW'(gbre_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gbre_back.sv =====
// ----------------------------------------------------------------------------
// gbre_back
// Drain queue entries one run per cycle, while out_ready allows, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbre_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [15:0]            cfg_wdata,
	input  wire gbre_pkg::queue_head_t  head,
	output logic                        pop,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [15:0]                 line_x,
	output logic [15:0]                 line_y,
	output logic [7:0]                  line_length,
	output logic [15:0]                 line_color,
	output logic                        out_last
);

	logic [15:0]                 color_q;
	logic [gbre_pkg::RUN_IW-1:0] ridx_q;
	logic                        out_valid_q;
	logic [15:0]                 x_q;
	logic [15:0]                 y_q;
	logic [7:0]                  len_q;
	logic                        last_q;
	logic                        take;
	logic                        run_last;

	assign take     = !out_valid_q || out_ready;
	assign run_last = (gbre_pkg::RUN_CW'(ridx_q) == (head.head.count - 1'b1));
	assign pop      = take && head.valid && run_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= gbre_pkg::DRAW_COLOR_RESET;
		end else if (cfg_we) begin
			color_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ridx_q      <= '0;
		end else if (take) begin
			out_valid_q <= head.valid;
			if (head.valid) begin
				ridx_q <= run_last ? '0 : ridx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && head.valid) begin
			x_q    <= head.head.x_base + {8'd0, head.head.begins[ridx_q]};
			y_q    <= head.head.y;
			len_q  <= head.head.lens[ridx_q];
			last_q <= run_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_x      = x_q;
	assign line_y      = y_q;
	assign line_length = len_q;
	assign line_color  = color_q;
	assign out_last    = last_q;

endmodule

`default_nettype wire

// ===== rtl/glyph_bitmap_run_extractor.sv =====
// ----------------------------------------------------------------------------
// glyph_bitmap_run_extractor
// Turn a 1bpp MSB-first row-padded glyph bitmap into horizontal line items.
// ----------------------------------------------------------------------------
// Usage:
//   Send a header item (s_tuser = 0) with the glyph geometry and pen origin,
//   then the bitmap bytes (s_tuser = 1), (width+7)/8 bytes per row, in order.
//   Each byte yields zero to five line items on the master side, in left to
//   right order; m_tlast marks the last line item caused by one input byte.
//   A run spanning bytes is reported by the byte that closes it; row end
//   always closes a run. Headers and bytes past the glyph yield nothing.
// Timing:
//   The front end takes one item per cycle while the queue is not full and
//   scans a byte in that cycle; its runs pass the queue and the output
//   register before showing on the master side. The back end sends one line
//   item per cycle while m_tready allows; the drain sets the sustained rate.
// Stall:
//   A two-entry queue sits between front and back. While m_tready is low,
//   the output register holds, the queue fills and then s_tready drops.
// Reset:
//   arst_n clears geometry (empty glyph, data ignored until a header), the
//   queue and the output valid; draw color returns to 0xFFFF. Write cfg
//   only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_bitmap_run_extractor #(
	parameter int MAX_GLYPH_WIDTH  = gbre_pkg::MAX_GLYPH_WIDTH_DEF,
	parameter int MAX_GLYPH_HEIGHT = gbre_pkg::MAX_GLYPH_HEIGHT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Draw color register
	input  wire logic                            cfg_we,
	input  wire logic [15:0]                     cfg_wdata,
	// Input items
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// glyph_width[7:0], glyph_height[15:8], offset_x[26:16], offset_y[37:27],
	// valid_byte_count[50:38], pen_x[66:51], base_y[82:67], data_byte[90:83],
	// zero pad [95:91]
	input  wire logic [gbre_pkg::S_TDATA_W-1:0]  s_tdata,
	// kind[0]
	input  wire logic [0:0]                      s_tuser,
	// Line items
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// line_x[15:0], line_y[31:16], line_length[39:32], line_color[55:40]
	output logic [gbre_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic                                 m_tlast
);

	logic                   q_full;
	logic                   q_push;
	logic                   q_pop;
	gbre_pkg::run_entry_t   q_entry;
	gbre_pkg::queue_head_t  q_head;
	logic [15:0]            line_x;
	logic [15:0]            line_y;
	logic [7:0]             line_length;
	logic [15:0]            line_color;

	// Classify items and scan bytes for completed runs
	gbre_front #(
		.MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
		.MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_tvalid),
		.in_ready         (s_tready),
		.in_kind          (s_tuser[0]),
		.glyph_width      (s_tdata[7:0]),
		.glyph_height     (s_tdata[15:8]),
		.offset_x         (s_tdata[26:16]),
		.offset_y         (s_tdata[37:27]),
		.valid_byte_count (s_tdata[50:38]),
		.pen_x            (s_tdata[66:51]),
		.base_y           (s_tdata[82:67]),
		.data_byte        (s_tdata[90:83]),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_entry          (q_entry)
	);

	// Decouple scan from drain
	gbre_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head)
	);

	// Emit one line item per cycle while m_tready allows
	gbre_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.line_x      (line_x),
		.line_y      (line_y),
		.line_length (line_length),
		.line_color  (line_color),
		.out_last    (m_tlast)
	);

	assign m_tdata = {line_color, line_length, line_y, line_x};

endmodule

`default_nettype wire
